/* rtl/assert_macros.svh */
// Assertion macros shared by the decoder RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

/* rtl/u8u16_pkg.sv */
// Types and constants for the UTF-8 to UTF-16 decoder.
// No dependencies; imported by utf8_to_utf16_decoder_core.
`default_nettype none

package u8u16_pkg;

    typedef enum logic [1:0] {
        KIND_UNIT  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef struct packed {
        logic [15:0] code_unit;
        t_kind       item_kind;
        logic [15:0] unit_count;
        logic        last_item;
    } t_item;

    localparam logic [20:0] SUPP_BASE    = 21'h010000;
    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
    localparam logic [15:0] SURR_HI_OFS  = 16'h0040;
    localparam logic [7:0]  LEAD_E0      = 8'hE0;
    localparam logic [7:0]  LEAD_F0      = 8'hF0;
    localparam logic [7:0]  LEAD_F4      = 8'hF4;
    localparam logic [15:0] LIMIT_RESET  = 16'hFFFF;

endpackage

`default_nettype wire

/* rtl/utf8_to_utf16_decoder_core.sv */
// Results of an accepted byte are written into the result queue and reach the output
// behind any older items. Takes one byte per cycle while the result side takes a transfer
// every cycle; a byte giving two or three results (pair, unit plus final status, or pair
// plus final status) holds the input until the queue is back down to at most one item.
// Reset (i_rst_n low, synchronous) clears decode state, result queue, and
// sets the output limit to 65535.
// Top level of the UTF-8 to UTF-16 stream decoder; depends on u8u16_pkg and
// assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module utf8_to_utf16_decoder_core
    import u8u16_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: output limit in code units per buffer
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    // byte input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    // result channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_code_unit,
    output logic [1:0]       o_item_kind,
    output logic [15:0]      o_unit_count,
    output logic             o_last_item
);

    // Compare width covers both the unit counter and the 16-bit limit.
    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    // Result queue: four slots, input stalls unless three are free.
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int MAXRES = 3;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    logic [15:0]           r_limit;
    logic [2:0]            r_rem,  n_rem;     // continuation bytes still due
    logic [2:0]            r_len,  n_len;     // nominal sequence length
    logic [20:0]           r_acc,  n_acc;     // code point under assembly
    logic [7:0]            r_lead, n_lead;
    logic                  r_bad,  n_bad;
    logic [COUNT_BITS-1:0] r_units, n_units;
    logic                  r_full, n_full;    // output limit reached
    logic                  r_err,  n_err;     // error seen in this buffer

    t_item                 r_q [QDEPTH];
    logic [QPW-1:0]        r_wr, r_rd;
    logic [QPW:0]          r_cnt;

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    logic in_xfer, out_xfer;

    assign o_stall  = (r_cnt > (QPW+1)'(QDEPTH - MAXRES));
    assign in_xfer  = i_valid && !o_stall;
    assign o_valid  = (r_cnt != '0);
    assign out_xfer = o_valid && !i_stall;

    // ---------------------------------------------------------------
    // Decode: one byte in, up to three result items out
    // ---------------------------------------------------------------
    t_item       items [MAXRES];
    logic [1:0]  n_items;
    logic        done, err_now, cont_bad;
    logic [2:0]  len, pos;
    logic [7:0]  mask;
    logic [20:0] ch;
    logic [CW:0] units_ext, limit_ext, n_units_ext;
    logic [15:0] hi_unit;

    assign units_ext   = (CW+1)'(r_units);
    assign limit_ext   = (CW+1)'(r_limit);
    assign n_units_ext = (CW+1)'(n_units);

    always_comb begin
        n_rem    = r_rem;
        n_len    = r_len;
        n_acc    = r_acc;
        n_lead   = r_lead;
        n_bad    = r_bad;
        n_units  = r_units;
        n_full   = r_full;
        n_err    = r_err;
        done     = 1'b0;
        err_now  = 1'b0;
        cont_bad = 1'b0;
        len      = 3'd1;
        mask     = 8'h7F;
        pos      = r_len - r_rem;
        ch       = '0;
        hi_unit  = '0;
        n_items  = '0;
        for (int i = 0; i < MAXRES; i++) begin
            items[i] = '{code_unit: '0, item_kind: KIND_UNIT, unit_count: '0, last_item: 1'b0};
        end

        if (in_xfer && !r_err && !r_full) begin
            if (r_rem == '0) begin
                if (units_ext >= limit_ext) begin
                    // no room left: ignore the rest of the buffer unchecked
                    n_full = 1'b1;
                end else begin
                    if (i_in_byte < 8'hC0) begin
                        len = 3'd1; mask = 8'h7F;
                    end else if (i_in_byte < 8'hE0) begin
                        len = 3'd2; mask = 8'h1F;
                    end else if (i_in_byte < 8'hF0) begin
                        len = 3'd3; mask = 8'h0F;
                    end else if (i_in_byte < 8'hF8) begin
                        len = 3'd4; mask = 8'h07;
                    end else if (i_in_byte < 8'hFC) begin
                        len = 3'd5; mask = 8'h00;
                    end else begin
                        len = 3'd6; mask = 8'h00;
                    end
                    n_lead = i_in_byte;
                    n_len  = len;
                    n_rem  = len - 3'd1;
                    n_acc  = 21'(i_in_byte & mask);
                    // stray continuation, overlong C0/C1, and leads above F4
                    n_bad  = (i_in_byte inside {[8'h80:8'hC1]}) || (i_in_byte > LEAD_F4);
                    done   = (len == 3'd1);
                end
            end else begin
                if (pos == 3'd1) begin
                    if (r_lead == LEAD_E0) begin
                        cont_bad = !(i_in_byte inside {[8'hA0:8'hBF]});
                    end else if (r_lead == LEAD_F0) begin
                        cont_bad = !(i_in_byte inside {[8'h90:8'hBF]});
                    end else if (r_lead == LEAD_F4) begin
                        cont_bad = !(i_in_byte inside {[8'h80:8'h8F]});
                    end else begin
                        cont_bad = !(i_in_byte inside {[8'h80:8'hBF]});
                    end
                end else begin
                    cont_bad = !(i_in_byte inside {[8'h80:8'hBF]});
                end
                n_bad = r_bad || cont_bad;
                n_acc = {r_acc[14:0], i_in_byte[5:0]};
                n_rem = r_rem - 3'd1;
                done  = (r_rem == 3'd1);
            end
        end

        if (done) begin
            ch      = n_acc;
            hi_unit = SURR_HI_BASE | ({5'b0, ch[20:10]} - SURR_HI_OFS);
            if (n_bad) begin
                err_now = 1'b1;
            end else if (ch < SUPP_BASE) begin
                items[0].code_unit = ch[15:0];
                n_items = 2'd1;
                n_units = r_units + COUNT_BITS'(1);
            end else if (units_ext + (CW+1)'(2) <= limit_ext) begin
                items[0].code_unit = hi_unit;
                items[1].code_unit = SURR_LO_BASE | {6'b0, ch[9:0]};
                n_items = 2'd2;
                n_units = r_units + COUNT_BITS'(2);
            end else begin
                // pair without room for both units
                err_now = 1'b1;
            end
            if (err_now) begin
                n_err = 1'b1;
                items[n_items].item_kind  = KIND_ERROR;
                items[n_items].unit_count = units_ext[15:0];
                items[n_items].last_item  = i_in_last;
                n_items = n_items + 2'd1;
            end
            n_len = '0;
            n_bad = 1'b0;
            n_acc = '0;
        end

        if (in_xfer && i_in_last) begin
            // final status, unless an error item already closed the buffer
            if (!err_now) begin
                items[n_items].item_kind  = n_err ? KIND_ERROR : KIND_DONE;
                items[n_items].unit_count = n_units_ext[15:0];
                items[n_items].last_item  = 1'b1;
                n_items = n_items + 2'd1;
            end
            n_rem   = '0;
            n_len   = '0;
            n_acc   = '0;
            n_lead  = '0;
            n_bad   = 1'b0;
            n_units = '0;
            n_full  = 1'b0;
            n_err   = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // State registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
            r_rem   <= '0;
            r_len   <= '0;
            r_acc   <= '0;
            r_lead  <= '0;
            r_bad   <= 1'b0;
            r_units <= '0;
            r_full  <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (in_xfer) begin
                r_rem   <= n_rem;
                r_len   <= n_len;
                r_acc   <= n_acc;
                r_lead  <= n_lead;
                r_bad   <= n_bad;
                r_units <= n_units;
                r_full  <= n_full;
                r_err   <= n_err;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result queue: push up to three items, pop one per transfer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAXRES; i++) begin
            if (in_xfer && (2'(i) < n_items)) begin
                r_q[r_wr + QPW'(i)] <= items[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (in_xfer) begin
                r_wr <= r_wr + QPW'(n_items);
            end
            if (out_xfer) begin
                r_rd <= r_rd + QPW'(1);
            end
            r_cnt <= r_cnt + (in_xfer ? (QPW+1)'(n_items) : '0)
                           - (out_xfer ? (QPW+1)'(1) : '0);
        end
    end

    assign o_code_unit  = r_q[r_rd].code_unit;
    assign o_item_kind  = r_q[r_rd].item_kind;
    assign o_unit_count = r_q[r_rd].unit_count;
    assign o_last_item  = r_q[r_rd].last_item;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    logic last_xfer, buf_idle;

    assign last_xfer = in_xfer && i_in_last;
    assign buf_idle  = (r_units == '0) && (r_rem == '0) && !r_err && !r_full;

    `ASSERT_CLK(a_q_bound, r_cnt <= (QPW+1)'(QDEPTH), "result queue overflow")
    `ASSERT_CLK(a_last_gives_result, last_xfer |=> (r_cnt != '0), "last byte gave no result")
    `ASSERT_CLK(a_last_clears, last_xfer |=> buf_idle, "buffer state not cleared")
    `ASSERT_NEVER(a_full_and_err, r_full && r_err, "full and error both set")

endmodule

`default_nettype wire

/* dv/utf8_to_utf16_decoder_core_tb.sv */
// Self-checking testbench for utf8_to_utf16_decoder_core: byte stream in,
// UTF-16 units and per-buffer status out, checked against an in-bench decoder.
// Depends on u8u16_pkg and the decoder RTL; needs no files or arguments.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_core_tb;
    import u8u16_pkg::*;

    localparam int unsigned DRAIN_CYCLES   = 4;    // settle time after the last owed item; leave margin
    localparam int unsigned HOLDOFF_CYCLES = 60;
    localparam int unsigned REPORT_LIMIT   = 10;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [15:0] i_cfg_wr_data = 16'd0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_in_byte     = 8'd0;
    logic        i_in_last     = 1'b0;
    logic        i_stall       = 1'b0;
    wire         o_stall;
    wire         o_valid;
    wire  [15:0] o_code_unit;
    wire  [1:0]  o_item_kind;
    wire  [15:0] o_unit_count;
    wire         o_last_item;

    utf8_to_utf16_decoder_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_code_unit  (o_code_unit),
        .o_item_kind  (o_item_kind),
        .o_unit_count (o_unit_count),
        .o_last_item  (o_last_item)
    );

    // Decoder shadow state, advanced once per accepted byte.
    logic [2:0]  dec_remaining;
    logic [2:0]  dec_length;
    logic [20:0] dec_acc;
    logic [7:0]  dec_lead;
    logic        dec_bad;
    logic [15:0] dec_units;
    logic        dec_full;
    logic        dec_err;
    logic [15:0] limit_shadow = LIMIT_RESET;

    t_item       expected_items[$];   // decoded items still owed by the block
    logic [7:0]  pending_bytes[$];    // bytes of the buffer being built
    int unsigned mismatch_count   = 0;
    int unsigned tx_idle_pct      = 15;
    int unsigned rx_stall_pct     = 74;
    int unsigned holdoff_request  = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or drops a result.
    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic t_item make_item(logic [15:0] unit, t_kind kind, logic [15:0] count,
                                        logic last);
        t_item it;
        it.code_unit  = unit;
        it.item_kind  = kind;
        it.unit_count = count;
        it.last_item  = last;
        return it;
    endfunction

    function automatic void clear_decoder();
        dec_remaining = 3'd0;
        dec_length    = 3'd0;
        dec_acc       = 21'd0;
        dec_lead      = 8'd0;
        dec_bad       = 1'b0;
        dec_units     = 16'd0;
        dec_full      = 1'b0;
        dec_err       = 1'b0;
    endfunction

    // Advance the shadow decoder by one byte and queue the items it owes.
    function automatic void predict_decode(logic [7:0] b, logic last);
        logic        done;
        logic        err_now;
        logic        bad;
        logic [2:0]  pos;
        logic [15:0] hi_unit;
        done    = 1'b0;
        err_now = 1'b0;
        if (!dec_err && !dec_full) begin
            if (dec_remaining == 3'd0) begin
                if (dec_units >= limit_shadow) begin
                    // Output full: ignore the rest of the buffer unchecked.
                    dec_full = 1'b1;
                end else begin
                    dec_lead = b;
                    if (b < 8'hC0) begin
                        dec_length = 3'd1;
                        dec_acc    = {14'd0, b[6:0]};
                    end else if (b < 8'hE0) begin
                        dec_length = 3'd2;
                        dec_acc    = {16'd0, b[4:0]};
                    end else if (b < 8'hF0) begin
                        dec_length = 3'd3;
                        dec_acc    = {17'd0, b[3:0]};
                    end else if (b < 8'hF8) begin
                        dec_length = 3'd4;
                        dec_acc    = {18'd0, b[2:0]};
                    end else if (b < 8'hFC) begin
                        dec_length = 3'd5;
                        dec_acc    = 21'd0;
                    end else begin
                        dec_length = 3'd6;
                        dec_acc    = 21'd0;
                    end
                    dec_remaining = dec_length - 3'd1;
                    // Bad leads still swallow their nominal continuation count.
                    dec_bad = (b >= 8'h80 && b < 8'hC2) || b > LEAD_F4;
                    done    = (dec_remaining == 3'd0);
                end
            end else begin
                pos = dec_length - dec_remaining;
                if (pos == 3'd1 && dec_lead == LEAD_E0)
                    bad = b < 8'hA0 || b > 8'hBF;
                else if (pos == 3'd1 && dec_lead == LEAD_F0)
                    bad = b < 8'h90 || b > 8'hBF;
                else if (pos == 3'd1 && dec_lead == LEAD_F4)
                    bad = b < 8'h80 || b > 8'h8F;
                else
                    bad = b < 8'h80 || b > 8'hBF;
                if (bad)
                    dec_bad = 1'b1;
                dec_acc       = {dec_acc[14:0], b[5:0]};
                dec_remaining = dec_remaining - 3'd1;
                done          = (dec_remaining == 3'd0);
            end
        end

        if (done) begin
            if (dec_bad) begin
                err_now = 1'b1;
            end else if (dec_acc < SUPP_BASE) begin
                expected_items.push_back(make_item(dec_acc[15:0], KIND_UNIT, 16'd0, 1'b0));
                dec_units = dec_units + 16'd1;
            end else if ({1'b0, dec_units} + 17'd2 <= {1'b0, limit_shadow}) begin
                hi_unit = SURR_HI_BASE | ({5'd0, dec_acc[20:10]} - SURR_HI_OFS);
                expected_items.push_back(make_item(hi_unit, KIND_UNIT, 16'd0, 1'b0));
                expected_items.push_back(make_item(SURR_LO_BASE | {6'd0, dec_acc[9:0]},
                                                   KIND_UNIT, 16'd0, 1'b0));
                dec_units = dec_units + 16'd2;
            end else begin
                // Pair without room for both units.
                err_now = 1'b1;
            end
            if (err_now) begin
                dec_err = 1'b1;
                expected_items.push_back(make_item(16'd0, KIND_ERROR, dec_units, last));
            end
            dec_length = 3'd0;
            dec_bad    = 1'b0;
            dec_acc    = 21'd0;
        end

        if (last) begin
            // An error raised on the last byte is itself the final item.
            if (!err_now)
                expected_items.push_back(make_item(16'd0, dec_err ? KIND_ERROR : KIND_DONE,
                                                   dec_units, 1'b1));
            clear_decoder();
        end
    endfunction

    initial clear_decoder();

    // Receiver: random stalls, or a long counted hold-off on request.
    always @(posedge i_clk) begin : result_receiver
        int unsigned hold_left;
        if (holdoff_request != 0) begin
            hold_left       = holdoff_request;
            holdoff_request = 0;
        end
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Checker: every transfer on the result side must match the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_items.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: unit=%h kind=%0d count=%0d last=%b",
                             o_code_unit, o_item_kind, o_unit_count, o_last_item);
            end else begin
                want = expected_items.pop_front();
                if (o_code_unit !== want.code_unit || o_item_kind !== want.item_kind ||
                    o_unit_count !== want.unit_count || o_last_item !== want.last_item) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: exp unit=%h kind=%0d count=%0d last=%b,",
                                 want.code_unit, want.item_kind, want.unit_count,
                                 want.last_item,
                                 " got unit=%h kind=%0d count=%0d last=%b",
                                 o_code_unit, o_item_kind, o_unit_count, o_last_item);
                end
            end
        end
    end

    // Offer one byte, hold it until the transfer, then advance the shadow decoder.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_in_last <= last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        predict_decode(b, last);
    endtask

    task automatic stop_sending();
        i_valid <= 1'b0;
    endtask

    // Wait for every owed item, then let any byte still in flight settle.
    task automatic wait_for_results();
        do
            @(posedge i_clk);
        while (expected_items.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_pending(input bit mark_last);
        int unsigned n;
        n = pending_bytes.size();
        for (int unsigned i = 0; i < n; i++)
            send_byte(pending_bytes[i], mark_last && (i == n - 1));
        pending_bytes.delete();
    endtask

    // Only write the limit with the block idle between buffers.
    task automatic write_out_limit(input logic [15:0] value);
        stop_sending();
        wait_for_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        limit_shadow = value;
    endtask

    function automatic void push_code_point(logic [20:0] cp);
        if (cp < 21'h80) begin
            pending_bytes.push_back(cp[7:0]);
        end else if (cp < 21'h800) begin
            pending_bytes.push_back({3'b110, cp[10:6]});
            pending_bytes.push_back({2'b10, cp[5:0]});
        end else if (cp < SUPP_BASE) begin
            pending_bytes.push_back({4'b1110, cp[15:12]});
            pending_bytes.push_back({2'b10, cp[11:6]});
            pending_bytes.push_back({2'b10, cp[5:0]});
        end else begin
            pending_bytes.push_back({5'b11110, cp[20:18]});
            pending_bytes.push_back({2'b10, cp[17:12]});
            pending_bytes.push_back({2'b10, cp[11:6]});
            pending_bytes.push_back({2'b10, cp[5:0]});
        end
    endfunction

    // Pick a code point of random encoded length; multi excludes plain ASCII.
    function automatic logic [20:0] random_code_point(bit multi);
        int unsigned r;
        case ($urandom_range(3, multi ? 1 : 0))
            0:       r = $urandom_range(32'h7F);
            1:       r = $urandom_range(32'h7FF, 32'h80);
            2:       r = $urandom_range(32'hFFFF, 32'h800);
            default: r = $urandom_range(32'h10FFFF, 32'h10000);
        endcase
        return r[20:0];
    endfunction

    // Lead bytes with tight second-byte ranges, the surrogate lead ED, or never-valid leads.
    function automatic logic [7:0] picky_lead();
        case ($urandom_range(7))
            0:       return LEAD_E0;
            1:       return LEAD_F0;
            2:       return LEAD_F4;
            3:       return 8'hED;
            4:       return 8'hC0;
            5:       return 8'hC1;
            6:       return 8'hF5;
            default: return 8'hFF;
        endcase
    endfunction

    // Build one buffer: mostly well-formed sequences, some noise and broken ones.
    function automatic void queue_random_buffer();
        int unsigned count;
        int unsigned pick;
        int unsigned start;
        int unsigned pos;
        int unsigned r;
        count = $urandom_range(6, 1);
        for (int unsigned i = 0; i < count; i++) begin
            pick  = $urandom_range(99);
            start = pending_bytes.size();
            if (pick < 80) begin
                push_code_point(random_code_point(1'b0));
            end else if (pick < 85) begin
                r = $urandom_range(255);
                pending_bytes.push_back(r[7:0]);
            end else if (pick < 90) begin
                // corrupt one continuation byte
                push_code_point(random_code_point(1'b1));
                pos = $urandom_range(pending_bytes.size() - 1, start + 1);
                r   = $urandom_range(255);
                pending_bytes[pos] = r[7:0];
            end else if (pick < 95) begin
                // drop the tail: cut off at buffer end, broken by the next lead otherwise
                push_code_point(random_code_point(1'b1));
                void'(pending_bytes.pop_back());
            end else begin
                pending_bytes.push_back(picky_lead());
                repeat ($urandom_range(5, 1)) begin
                    r = $urandom_range(8'hBF, 8'h70);
                    pending_bytes.push_back(r[7:0]);
                end
            end
        end
    endfunction

    // One, two, three and four byte forms, surrogates passed through, F4 upper bound.
    task automatic test_valid_forms();
        write_out_limit(LIMIT_RESET);
        pending_bytes = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hED, 8'hA0, 8'h80,
                          8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_pending(1'b1);
    endtask

    // Bad lead at the start of a buffer, then a sequence cut off by the end of a buffer.
    task automatic test_bad_sequences();
        pending_bytes = '{8'hC0, 8'h80, 8'h00};
        send_pending(1'b1);
        pending_bytes = '{8'hC3};
        send_pending(1'b1);
    endtask

    // Zero capacity, pair without room on the last byte, and stop when full.
    task automatic test_output_limit();
        write_out_limit(16'd0);
        pending_bytes = '{8'h41};
        send_pending(1'b1);
        write_out_limit(16'd2);
        pending_bytes = '{8'hE0, 8'hA0, 8'h80, 8'hF0, 8'h90, 8'h80, 8'h80};
        send_pending(1'b1);
        write_out_limit(16'd1);
        pending_bytes = '{8'h41, 8'h42, 8'hFF};
        send_pending(1'b1);
    endtask

    // Hold off the result side while bytes keep coming, so the input backs up.
    task automatic test_result_holdoff();
        write_out_limit(LIMIT_RESET);
        tx_idle_pct     = 0;
        holdoff_request = HOLDOFF_CYCLES;
        repeat (8) push_code_point(random_code_point(1'b0));
        send_pending(1'b1);
        tx_idle_pct = 15;
    endtask

    // Pause the sender mid-buffer until every owed result is out.
    task automatic test_sender_pause();
        repeat (3) push_code_point(random_code_point(1'b0));
        send_pending(1'b0);
        stop_sending();
        wait_for_results();
        repeat (3) push_code_point(random_code_point(1'b0));
        send_pending(1'b1);
    endtask

    task automatic run_random_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                                    input logic [15:0] limit, input int unsigned target);
        int unsigned sent;
        write_out_limit(limit);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        sent = 0;
        while (sent < target) begin
            queue_random_buffer();
            sent += pending_bytes.size();
            send_pending(1'b1);
        end
    endtask

    // Three idling profiles: two under a random small output limit, one under the reset limit.
    task automatic test_random_traffic();
        int unsigned r;
        r = $urandom_range(8, 1);
        run_random_phase(15, 74, r[15:0], 12);
        run_random_phase(74, 15, LIMIT_RESET, 12);
        r = $urandom_range(12, 2);
        run_random_phase(0, 0, r[15:0], 12);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_valid_forms();
        test_bad_sequences();
        test_output_limit();
        test_result_holdoff();
        test_sender_pause();
        test_random_traffic();
        stop_sending();
        wait_for_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_items.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
